[sv/fir_resampler_by_six_unit_assert.svh]
// Assertion macros for the resampler block.
// Define ASSERT_OFF to compile them out; no other dependencies.
`ifndef FIR_RESAMPLER_BY_SIX_UNIT_ASSERT_SVH
`define FIR_RESAMPLER_BY_SIX_UNIT_ASSERT_SVH
`ifndef ASSERT_OFF
`define FRS_ASSERT_IMP(lbl, clk, rst_n, ant, con, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ant) |-> (con)) \
        else $error(msg);
`define FRS_ASSERT_NXT(lbl, clk, rst_n, ant, con, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ant) |=> (con)) \
        else $error(msg);
`else
`define FRS_ASSERT_IMP(lbl, clk, rst_n, ant, con, msg)
`define FRS_ASSERT_NXT(lbl, clk, rst_n, ant, con, msg)
`endif
`endif

[sv/frs_pkg.sv]
// Shared types, constants and the tap table of the resampler.
// No dependencies.
package frs_pkg;

    localparam int COEF_W    = 18;
    localparam int GAIN_W    = 16;
    localparam int GAIN_FRAC = 12;
    localparam int TABLE_LEN = 42;

    localparam logic [1:0] MODE_INTERP = 2'd0;
    localparam logic [1:0] MODE_DECIM  = 2'd1;
    localparam logic [1:0] MODE_CLEAR  = 2'd2;

    localparam logic CFG_UP_GAIN   = 1'b0;
    localparam logic CFG_DOWN_GAIN = 1'b1;

    localparam logic [GAIN_W-1:0] UP_GAIN_RST   = 16'd24576;
    localparam logic [GAIN_W-1:0] DOWN_GAIN_RST = 16'd3686;

    localparam logic signed [COEF_W-1:0] TAP_TABLE [TABLE_LEN] = '{
        18'sd159, 18'sd179, 18'sd190, 18'sd169, 18'sd81, -18'sd109, -18'sd416,
        -18'sd821, -18'sd1255, -18'sd1606, -18'sd1721, -18'sd1442, -18'sd632,
        18'sd788, 18'sd2810, 18'sd5322, 18'sd8116, 18'sd10907, 18'sd13378,
        18'sd15226, 18'sd16214, 18'sd16214, 18'sd15226, 18'sd13378, 18'sd10907,
        18'sd8116, 18'sd5322, 18'sd2810, 18'sd788, -18'sd632, -18'sd1442,
        -18'sd1721, -18'sd1606, -18'sd1255, -18'sd821, -18'sd416, -18'sd109,
        18'sd81, 18'sd169, 18'sd190, 18'sd179, 18'sd159
    };

    typedef struct packed {
        logic clr;
        logic mul_en;
        logic scale_en;
    } t_mac_ctl;

    function automatic logic signed [COEF_W-1:0] tap_coef(input logic [7:0] idx);
        logic signed [COEF_W-1:0] c;
        c = '0;
        if (idx < 8'(TABLE_LEN)) begin
            c = TAP_TABLE[idx[5:0]];
        end
        return c;
    endfunction

endpackage

[sv/frs_cell.sv]
// One history cell of the sample ring: loads its neighbor's sample when enabled.
// No dependencies.
module frs_cell #(
    parameter int WIDTH = 16
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_clr,
    input  logic                    i_en,
    input  logic signed [WIDTH-1:0] i_prev,
    output logic signed [WIDTH-1:0] o_data
);

    logic signed [WIDTH-1:0] r_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clr) begin
            r_data <= '0;
        end else if (i_en) begin
            r_data <= i_prev;
        end
    end

    assign o_data = r_data;

endmodule

[sv/frs_mac.sv]
// Multiply-accumulate, gain scaling, rounding and saturation of the filter.
// Depends on frs_pkg.
module frs_mac #(
    parameter int TAPS         = 42,
    parameter int SAMPLE_WIDTH = 16
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  frs_pkg::t_mac_ctl                  i_ctl,
    input  logic signed [SAMPLE_WIDTH-1:0]     i_sample,
    input  logic signed [frs_pkg::COEF_W-1:0]  i_coef,
    input  logic [frs_pkg::GAIN_W-1:0]         i_gain,
    output logic signed [SAMPLE_WIDTH-1:0]     o_result
);
    import frs_pkg::*;

    localparam int MUL_W  = SAMPLE_WIDTH + COEF_W;
    localparam int ACC_W  = MUL_W + $clog2(TAPS);
    localparam int PROD_W = ACC_W + GAIN_W + 1;
    localparam int SHIFT  = COEF_W - 1 + GAIN_FRAC;
    localparam logic signed [PROD_W-1:0] SAT_MAX =
        {{(PROD_W-SAMPLE_WIDTH+1){1'b0}}, {(SAMPLE_WIDTH-1){1'b1}}};
    localparam logic signed [PROD_W-1:0] SAT_MIN = ~SAT_MAX;
    localparam logic signed [PROD_W-1:0] RND     = PROD_W'(1) <<< (SHIFT-1);

    logic signed [MUL_W-1:0]  r_prod;
    logic                     r_pv;
    logic signed [ACC_W-1:0]  r_acc;
    logic signed [PROD_W-1:0] r_sprod;
    logic signed [PROD_W-1:0] w_rnd;
    logic signed [PROD_W-1:0] w_shr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pv <= 1'b0;
        end else begin
            r_pv <= i_ctl.mul_en;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.mul_en) begin
            r_prod <= i_sample * i_coef;
        end
        if (i_ctl.clr) begin
            r_acc <= '0;
        end else if (r_pv) begin
            r_acc <= r_acc + ACC_W'(r_prod);
        end
        if (i_ctl.scale_en) begin
            r_sprod <= r_acc * $signed({1'b0, i_gain});
        end
    end

    assign w_rnd = r_sprod + RND;
    assign w_shr = w_rnd >>> SHIFT;

    always_comb begin
        if (w_shr > SAT_MAX) begin
            o_result = SAT_MAX[SAMPLE_WIDTH-1:0];
        end else if (w_shr < SAT_MIN) begin
            o_result = SAT_MIN[SAMPLE_WIDTH-1:0];
        end else begin
            o_result = w_shr[SAMPLE_WIDTH-1:0];
        end
    end

endmodule

[sv/fir_resampler_by_six_unit.sv]
// Top level of the by-six FIR resampler: control, history ring and MAC.
// Depends on frs_pkg, frs_cell, frs_mac and fir_resampler_by_six_unit_assert.svh.
//
// Input channel (i_valid/o_ready) takes one request: a mode and a sample.
// Interpolate yields RATIO results, the final one with o_last set; decimate
// yields one result (o_last set) on every RATIO-th decimate request; clear
// zeroes the history and decimation phase and yields nothing.
// Output channel (o_valid/i_ready) is one output register.
// Each filter pass is one shift of the ring, then TAPS steps in which the ring
// rotates past the single multiplier, then drain, scale and round.
// Interpolate holds the input for RATIO passes, decimate for one pass;
// clear or unused mode leaves the block idle.
// A new request is taken while the last result still waits in the register.
// If the receiver stalls, the next result holds in the round stage and the
// block waits. Reset clears history, phase and gains to defaults.
// Gains are written through i_cfg_we/i_cfg_idx/i_cfg_data; the user must write
// them only while idle, as the block itself does not enforce it.
module fir_resampler_by_six_unit #(
    parameter int TAPS         = 42,
    parameter int RATIO        = 6,
    parameter int SAMPLE_WIDTH = 16
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_ready,
    input  logic [1:0]                     i_mode,
    input  logic signed [SAMPLE_WIDTH-1:0] i_in_sample,
    output logic                           o_valid,
    input  logic                           i_ready,
    output logic signed [SAMPLE_WIDTH-1:0] o_out_sample,
    output logic                           o_last,
    input  logic                           i_cfg_we,
    input  logic                           i_cfg_idx,
    input  logic [frs_pkg::GAIN_W-1:0]     i_cfg_data
);
    import frs_pkg::*;

    localparam int TAP_W = (TAPS > 1) ? $clog2(TAPS) : 1;
    localparam int PH_W  = (RATIO > 1) ? $clog2(RATIO) : 1;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_PUSH  = 3'd1;
    localparam logic [2:0] S_MAC   = 3'd2;
    localparam logic [2:0] S_DRAIN = 3'd3;
    localparam logic [2:0] S_SCALE = 3'd4;
    localparam logic [2:0] S_ROUND = 3'd5;

    logic [2:0]                    r_state, n_state;
    logic [TAP_W-1:0]              r_tap, n_tap;
    logic [PH_W-1:0]               r_push, n_push;
    logic [PH_W-1:0]               r_phase, n_phase;
    logic                          r_up, n_up;
    logic                          r_emit, n_emit;
    logic signed [SAMPLE_WIDTH-1:0] r_x, n_x;
    logic                          r_ov, n_ov;
    logic signed [SAMPLE_WIDTH-1:0] r_out, n_out;
    logic                          r_last, n_last;
    logic [GAIN_W-1:0]             r_up_gain, n_up_gain;
    logic [GAIN_W-1:0]             r_down_gain, n_down_gain;

    logic                          w_acc_in;
    logic                          w_load;
    logic                          w_cell_clr;
    logic                          w_cell_en;
    logic signed [SAMPLE_WIDTH-1:0] w_head_in;
    logic signed [SAMPLE_WIDTH-1:0] w_cell [TAPS];
    logic signed [SAMPLE_WIDTH-1:0] w_prev [TAPS];
    logic [TAP_W-1:0]              w_tidx;
    logic signed [COEF_W-1:0]      w_coef;
    logic signed [SAMPLE_WIDTH-1:0] w_result;
    t_mac_ctl                      w_ctl;

    assign o_ready  = (r_state == S_IDLE);
    assign w_acc_in = i_valid && o_ready;
    assign w_load   = (r_state == S_ROUND) && (r_up || r_emit) && (!r_ov || i_ready);

    assign w_cell_clr = w_acc_in && (i_mode == MODE_CLEAR);
    assign w_cell_en  = (r_state == S_PUSH) || (r_state == S_MAC);
    assign w_head_in  = (r_state == S_PUSH) ? ((r_push == '0) ? r_x : '0)
                                            : w_cell[TAPS-1];

    assign w_prev[0] = w_head_in;
    for (genvar g = 1; g < TAPS; g++) begin : g_link
        assign w_prev[g] = w_cell[g-1];
    end

    for (genvar g = 0; g < TAPS; g++) begin : g_cell
        frs_cell #(
            .WIDTH (SAMPLE_WIDTH)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_clr   (w_cell_clr),
            .i_en    (w_cell_en),
            .i_prev  (w_prev[g]),
            .o_data  (w_cell[g])
        );
    end

    assign w_tidx = TAP_W'(TAPS-1) - r_tap;
    assign w_coef = tap_coef(8'(w_tidx));

    assign w_ctl.clr      = (r_state == S_PUSH);
    assign w_ctl.mul_en   = (r_state == S_MAC);
    assign w_ctl.scale_en = (r_state == S_SCALE);

    frs_mac #(
        .TAPS         (TAPS),
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_mac (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (w_ctl),
        .i_sample (w_cell[TAPS-1]),
        .i_coef   (w_coef),
        .i_gain   (r_up ? r_up_gain : r_down_gain),
        .o_result (w_result)
    );

    always_comb begin
        n_state     = r_state;
        n_tap       = r_tap;
        n_push      = r_push;
        n_phase     = r_phase;
        n_up        = r_up;
        n_emit      = r_emit;
        n_x         = r_x;
        n_ov        = r_ov;
        n_out       = r_out;
        n_last      = r_last;
        n_up_gain   = r_up_gain;
        n_down_gain = r_down_gain;

        if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_UP_GAIN:   n_up_gain   = i_cfg_data;
                CFG_DOWN_GAIN: n_down_gain = i_cfg_data;
                default:       n_up_gain   = r_up_gain;
            endcase
        end

        if (r_ov && i_ready) begin
            n_ov = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (w_acc_in) begin
                    n_x    = i_in_sample;
                    n_push = '0;
                    case (i_mode)
                        MODE_INTERP: begin
                            n_up    = 1'b1;
                            n_emit  = 1'b0;
                            n_state = S_PUSH;
                        end
                        MODE_DECIM: begin
                            n_up    = 1'b0;
                            n_emit  = (r_phase == '0);
                            n_phase = (r_phase == PH_W'(RATIO-1)) ? '0 : r_phase + 1'b1;
                            n_state = S_PUSH;
                        end
                        MODE_CLEAR: begin
                            n_phase = '0;
                        end
                        default: begin
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end
            S_PUSH: begin
                n_tap   = '0;
                n_state = S_MAC;
            end
            S_MAC: begin
                if (r_tap == TAP_W'(TAPS-1)) begin
                    n_state = S_DRAIN;
                end else begin
                    n_tap = r_tap + 1'b1;
                end
            end
            S_DRAIN: begin
                n_state = S_SCALE;
            end
            S_SCALE: begin
                n_state = S_ROUND;
            end
            S_ROUND: begin
                if (!(r_up || r_emit)) begin
                    n_state = S_IDLE;
                end else if (w_load) begin
                    n_ov   = 1'b1;
                    n_out  = w_result;
                    n_last = !r_up || (r_push == PH_W'(RATIO-1));
                    if (r_up && (r_push != PH_W'(RATIO-1))) begin
                        n_push  = r_push + 1'b1;
                        n_state = S_PUSH;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_tap       <= '0;
            r_push      <= '0;
            r_phase     <= '0;
            r_up        <= 1'b0;
            r_emit      <= 1'b0;
            r_ov        <= 1'b0;
            r_up_gain   <= UP_GAIN_RST;
            r_down_gain <= DOWN_GAIN_RST;
        end else begin
            r_state     <= n_state;
            r_tap       <= n_tap;
            r_push      <= n_push;
            r_phase     <= n_phase;
            r_up        <= n_up;
            r_emit      <= n_emit;
            r_ov        <= n_ov;
            r_up_gain   <= n_up_gain;
            r_down_gain <= n_down_gain;
        end
    end

    always_ff @(posedge i_clk) begin
        r_x    <= n_x;
        r_out  <= n_out;
        r_last <= n_last;
    end

    assign o_valid      = r_ov;
    assign o_out_sample = r_out;
    assign o_last       = r_last;

`include "fir_resampler_by_six_unit_assert.svh"

    `FRS_ASSERT_IMP(a_tap_range, i_clk, i_rst_n, r_state == S_MAC, r_tap <= TAP_W'(TAPS-1), "tap counter out of range")
    `FRS_ASSERT_IMP(a_push_range, i_clk, i_rst_n, 1'b1, r_push <= PH_W'(RATIO-1), "push counter out of range")
    `FRS_ASSERT_NXT(a_last_idle, i_clk, i_rst_n, w_load && n_last, r_state == S_IDLE && r_ov && r_last, "last result did not end the request")
    `FRS_ASSERT_NXT(a_decim_emit, i_clk, i_rst_n, w_acc_in && i_mode == MODE_DECIM, r_emit == ($past(r_phase) == '0), "decimation phase mismatch")

endmodule

[sim/testbench.sv]
// Self-checking bench for fir_resampler_by_six_unit: random and directed requests
// against a bit-exact predictor of the 42-tap filter, gains and decimation phase.
// Depends on frs_pkg and the RTL of the block.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import frs_pkg::*;

    localparam int TAPS        = 42;
    localparam int RATIO       = 6;
    localparam int SCALE_SHIFT = 29;
    localparam longint ROUND_HALF = longint'(1) <<< (SCALE_SHIFT - 1);
    localparam int SETTLE      = 300;
    localparam int LONG_HOLD   = 1500;
    localparam int LIMIT       = 1000000;
    localparam logic [1:0] MODE_UNUSED = 2'd3;

    localparam int TAP_Q17 [TAPS] = '{
        159, 179, 190, 169, 81, -109, -416, -821, -1255, -1606,
        -1721, -1442, -632, 788, 2810, 5322, 8116, 10907, 13378, 15226,
        16214, 16214, 15226, 13378, 10907, 8116, 5322, 2810, 788, -632,
        -1442, -1721, -1606, -1255, -821, -416, -109, 81, 169, 190,
        179, 159
    };

    typedef struct packed {
        logic signed [15:0] sample;
        logic               last;
    } t_out_item;

    logic               i_clk       = 1'b0;
    logic               i_rst_n     = 1'b0;
    logic               i_valid     = 1'b0;
    logic [1:0]         i_mode      = MODE_INTERP;
    logic signed [15:0] i_in_sample = '0;
    logic               i_ready     = 1'b0;
    logic               i_cfg_we    = 1'b0;
    logic               i_cfg_idx   = CFG_UP_GAIN;
    logic [GAIN_W-1:0]  i_cfg_data  = '0;
    logic               o_ready;
    logic               o_valid;
    logic signed [15:0] o_out_sample;
    logic               o_last;

    logic signed [15:0] hist [TAPS];
    logic [2:0]         decim_phase_q;
    logic [GAIN_W-1:0]  up_gain_q;
    logic [GAIN_W-1:0]  down_gain_q;
    t_out_item          pending_outputs [$];

    int errors       = 0;
    int cycle_count  = 0;
    int holds_asked  = 0;
    int holds_served = 0;
    int stall_left   = 0;
    bit steady_flow  = 1'b0;

    fir_resampler_by_six_unit DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_mode       (i_mode),
        .i_in_sample  (i_in_sample),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_out_sample (o_out_sample),
        .o_last       (o_last),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // receiver: random stalls per result, plus long hold-offs on request
    always @(posedge i_clk) begin : rx_side
        int unsigned draw;
        if (!i_rst_n) begin
            i_ready    <= 1'b0;
            stall_left <= 0;
        end else if (holds_served != holds_asked) begin
            holds_served <= holds_asked;
            stall_left   <= LONG_HOLD;
            i_ready      <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            if (stall_left == 1) begin
                i_ready <= 1'b1;
            end
        end else if (!i_ready) begin
            i_ready <= 1'b1;
        end else if (o_valid) begin
            draw = steady_flow ? 0 : $urandom_range(0, 11);
            if (draw != 0) begin
                i_ready    <= 1'b0;
                stall_left <= draw;
            end
        end
    end

    always @(posedge i_clk) begin : result_check
        t_out_item want;
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_outputs.size() == 0) begin
                $display("%0t: unexpected result sample=%0d last=%0b",
                         $time, o_out_sample, o_last);
                errors++;
            end else begin
                want = pending_outputs.pop_front();
                if (o_out_sample !== want.sample) begin
                    $display("%0t: out_sample expected %0d actual %0d",
                             $time, want.sample, o_out_sample);
                    errors++;
                end
                if (o_last !== want.last) begin
                    $display("%0t: last expected %0b actual %0b", $time, want.last, o_last);
                    errors++;
                end
            end
        end
    end

    function automatic longint shift_in(logic signed [15:0] x);
        longint acc;
        acc = 0;
        for (int k = TAPS - 1; k > 0; k--) begin
            hist[k] = hist[k-1];
        end
        hist[0] = x;
        for (int k = 0; k < TAPS; k++) begin
            acc += longint'(TAP_Q17[k]) * longint'(hist[k]);
        end
        return acc;
    endfunction

    function automatic logic signed [15:0] round_sat(longint acc, logic [GAIN_W-1:0] gain);
        longint v;
        v = (acc * longint'({48'd0, gain}) + ROUND_HALF) >>> SCALE_SHIFT;
        if (v > 32767) begin
            return 16'sh7fff;
        end
        if (v < -32768) begin
            return 16'sh8000;
        end
        return v[15:0];
    endfunction

    function automatic void predict_request(logic [1:0] mode, logic signed [15:0] x);
        t_out_item r;
        longint acc;
        case (mode)
            MODE_INTERP: begin
                for (int k = 0; k < RATIO; k++) begin
                    acc = shift_in(k == 0 ? x : 16'sd0);
                    r.sample = round_sat(acc, up_gain_q);
                    r.last   = (k == RATIO - 1);
                    pending_outputs.push_back(r);
                end
            end
            MODE_DECIM: begin
                acc = shift_in(x);
                if (decim_phase_q == 0) begin
                    r.sample = round_sat(acc, down_gain_q);
                    r.last   = 1'b1;
                    pending_outputs.push_back(r);
                end
                decim_phase_q = (decim_phase_q == RATIO - 1) ? 3'd0 : decim_phase_q + 3'd1;
            end
            MODE_CLEAR: begin
                for (int k = 0; k < TAPS; k++) begin
                    hist[k] = '0;
                end
                decim_phase_q = '0;
            end
            default: ;
        endcase
    endfunction

    function automatic logic signed [15:0] pick_sample();
        case ($urandom_range(0, 7))
            0: return 16'sh7fff;
            1: return 16'sh8000;
            2: return 16'($signed($urandom_range(0, 31)) - 16);
            default: return 16'($urandom);
        endcase
    endfunction

    // called and returning at a rising edge
    task automatic send_request(input logic [1:0] mode, input logic signed [15:0] x);
        int gap;
        gap = steady_flow ? 0 : $urandom_range(0, 11);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid     <= 1'b1;
        i_mode      <= mode;
        i_in_sample <= x;
        do @(posedge i_clk); while (!o_ready);
        predict_request(mode, x);
    endtask

    task automatic write_gain(input logic idx, input logic [GAIN_W-1:0] value);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == CFG_UP_GAIN) begin
            up_gain_q = value;
        end else begin
            down_gain_q = value;
        end
        @(posedge i_clk);
    endtask

    task automatic wait_idle();
        i_valid <= 1'b0;
        while (pending_outputs.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic apply_reset();
        for (int k = 0; k < TAPS; k++) begin
            hist[k] = '0;
        end
        decim_phase_q = '0;
        up_gain_q     = UP_GAIN_RST;
        down_gain_q   = DOWN_GAIN_RST;
        i_rst_n <= 1'b0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
    endtask

    task automatic test_directed_modes();
        send_request(MODE_INTERP, 16'sh7fff);
        send_request(MODE_INTERP, 16'sh8000);
        send_request(MODE_DECIM, 16'sh7fff);
        send_request(MODE_DECIM, 16'sh8000);
        send_request(MODE_DECIM, 16'sd1);
        send_request(MODE_DECIM, -16'sd1);
        send_request(MODE_DECIM, 16'sh5555);
        send_request(MODE_DECIM, 16'shaaaa);
        send_request(MODE_DECIM, 16'sh7fff);
        send_request(MODE_UNUSED, 16'sh7fff);
        send_request(MODE_CLEAR, 16'sh7fff);
        send_request(MODE_DECIM, 16'sh8000);
    endtask

    task automatic test_gain_extremes();
        wait_idle();
        write_gain(CFG_UP_GAIN, 16'hffff);
        write_gain(CFG_DOWN_GAIN, 16'hffff);
        send_request(MODE_INTERP, 16'sh7fff);
        send_request(MODE_INTERP, 16'sh8000);
        send_request(MODE_DECIM, 16'sh7fff);
        send_request(MODE_CLEAR, 16'sd0);
        wait_idle();
        write_gain(CFG_UP_GAIN, 16'h0000);
        write_gain(CFG_DOWN_GAIN, 16'h0000);
        send_request(MODE_INTERP, 16'sh7fff);
        send_request(MODE_DECIM, 16'sh8000);
    endtask

    // hold the output side off while requests keep coming
    task automatic test_output_backpressure();
        holds_asked++;
        steady_flow = 1'b1;
        repeat (10) send_request(MODE_INTERP, pick_sample());
        repeat (12) send_request(MODE_DECIM, pick_sample());
        steady_flow = 1'b0;
    endtask

    task automatic test_random_mix(input int target);
        int sent;
        int kind;
        int run;
        sent = 0;
        while (sent < target) begin
            steady_flow = ($urandom_range(0, 7) == 0);
            kind = $urandom_range(0, 9);
            if (kind < 4) begin
                run = $urandom_range(1, 4);
                repeat (run) send_request(MODE_INTERP, pick_sample());
                sent += run;
            end else if (kind < 8) begin
                run = $urandom_range(1, 18);
                repeat (run) send_request(MODE_DECIM, pick_sample());
                sent += run;
            end else if (kind == 8) begin
                send_request(MODE_CLEAR, pick_sample());
                sent++;
            end else begin
                send_request(MODE_UNUSED, pick_sample());
            end
        end
        steady_flow = 1'b0;
    endtask

    task automatic run_gain_phase(input logic [GAIN_W-1:0] up, input logic [GAIN_W-1:0] down,
                                  input int target);
        wait_idle();
        write_gain(CFG_UP_GAIN, up);
        write_gain(CFG_DOWN_GAIN, down);
        test_random_mix(target);
    endtask

    initial begin
        apply_reset();
        test_directed_modes();
        test_gain_extremes();
        test_output_backpressure();
        run_gain_phase(16'($urandom), 16'($urandom), 150);
        run_gain_phase(16'hffff, 16'h0000, 80);
        run_gain_phase(16'h0000, 16'hffff, 80);
        run_gain_phase(UP_GAIN_RST, DOWN_GAIN_RST, 150);
        wait_idle();
        if (errors == 0 && pending_outputs.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
